FILE: sv/tgr_pkg.sv
// Shared types and constants for the text glyph row renderer.
package tgr_pkg;

  localparam int unsigned GLYPH_ROWS       = 16;
  localparam int unsigned FONT_CHARS       = 256;
  localparam int unsigned FONT_DEPTH       = GLYPH_ROWS * FONT_CHARS;
  localparam int unsigned ROW_W            = $clog2(GLYPH_ROWS);
  localparam int unsigned TEXT_COLUMNS_DEF = 80;

  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_VIS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_COL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_LINE   = 3'd5;

  localparam logic       FUNC_RENDER     = 1'b0;
  localparam logic       FUNC_LOAD       = 1'b1;
  localparam logic [5:0] BPP_TEXT        = 6'd0;
  localparam logic [5:0] BPP_32          = 6'd32;
  localparam logic [7:0] LINE_GFX_FIRST  = 8'hB0;
  localparam logic [7:0] LINE_GFX_LAST   = 8'hDF;
  localparam logic [7:0] REPLACE_CODE    = 8'hFF;
  localparam logic [7:0] REPLACE_CHAR    = 8'h3F;
  localparam logic [31:0] ALPHA_MASK     = 32'hFF000000;
  localparam logic [31:0] RGB_MASK       = 32'h00FFFFFF;
  localparam logic [ROW_W-1:0] CURSOR_ROW_FIRST = 4'd14;
  localparam logic [13:0] WIDTH_RESET    = 14'd640;

  typedef enum logic {
    ST_IDLE,
    ST_RENDER
  } state_e;

  function automatic logic [7:0] swap_nibbles(input logic [7:0] a);
    return {a[3:0], a[7:4]};
  endfunction

endpackage

FILE: sv/text_glyph_row_renderer_top.sv
// Top level of the text glyph row renderer: font memory, row sequencer and output register.
//
// Usage: items arrive on the s_axis channel, results leave on the m_axis channel.
// tuser carries func: 1 loads one font row into the glyph memory and gives no result,
// 0 renders the cell described by tdata. The cfg channel writes the six registers and
// is always ready; write it only while no render is in progress.
// A font load or a text mode render (bits per pixel 0) is handled at its transfer; the text
// result is registered and appears on m_axis in the cycle after the transfer. A packed pixel
// render emits sixteen row results, one per glyph row, at one per cycle while the receiver
// does not stall; each row passes the glyph memory read register and the output register
// after the render state is entered. The single read port of the glyph memory sets that rate,
// and s_axis_tready_o stays low during the render. tlast marks the final result of each cell.
// When the receiver stalls, the output register holds its result and the sequencer
// pauses with at most one fetched glyph row waiting at the memory output.
// Reset clears the registers to their defaults and aborts any render; the glyph memory
// is not cleared and must be loaded before its glyphs are rendered.
module text_glyph_row_renderer_top #(
  parameter int unsigned TEXT_COLUMNS = tgr_pkg::TEXT_COLUMNS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata, low bit up: cell_col, cell_line, char_code, glyph_row, font_bits, fg_color,
  // bg_color, text_attribute, zero fill.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [tgr_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,  // func
  // tdata, low bit up: byte_offset, fg_pixel_mask, pixel_write_mask, out_fg_color,
  // out_bg_color, text_char, text_attr_out, zero fill.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [tgr_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tgr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tgr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned RowW  = tgr_pkg::ROW_W;

  logic [7:0]  in_col, in_line, in_code, in_fbits, in_attr;
  logic [RowW-1:0] in_grow;
  logic [31:0] in_fg, in_bg;

  assign in_col   = s_axis_tdata_i[7:0];
  assign in_line  = s_axis_tdata_i[15:8];
  assign in_code  = s_axis_tdata_i[23:16];
  assign in_grow  = s_axis_tdata_i[27:24];
  assign in_fbits = s_axis_tdata_i[35:28];
  assign in_fg    = s_axis_tdata_i[67:36];
  assign in_bg    = s_axis_tdata_i[99:68];
  assign in_attr  = s_axis_tdata_i[107:100];

  logic [5:0]  bpp_q;
  logic [15:0] pitch_q;
  logic [13:0] width_q;
  logic        cur_vis_q;
  logic [7:0]  cur_col_q, cur_line_q;

  tgr_pkg::state_e state_q, state_d;

  logic [RowW:0]   issue_cnt_q, issue_cnt_d;
  logic [RowW-1:0] out_cnt_q, out_cnt_d;
  logic            pend_q, pend_d;
  logic            out_valid_q, out_valid_d;

  logic [7:0]  code_q;
  logic [31:0] fgc_q, bgc_q, row_off_q;
  logic        cursor_here_q, ninth_ok_q, line_gfx_q, fg_on_q, bg_on_q;

  logic [31:0] out_off_q, out_fgc_q, out_bgc_q;
  logic [8:0]  out_fgm_q, out_wm_q;
  logic [7:0]  out_ch_q, out_at_q;
  logic        out_last_q;

  logic in_xfer, load_font, start_text, start_pix, issue, load_row, render_done;
  logic [7:0] rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q      <= '0;
      pitch_q    <= '0;
      width_q    <= tgr_pkg::WIDTH_RESET;
      cur_vis_q  <= 1'b1;
      cur_col_q  <= '0;
      cur_line_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tgr_pkg::REG_BPP:      bpp_q      <= cfg_data_i[5:0];
        tgr_pkg::REG_PITCH:    pitch_q    <= cfg_data_i;
        tgr_pkg::REG_WIDTH:    width_q    <= cfg_data_i[13:0];
        tgr_pkg::REG_CUR_VIS:  cur_vis_q  <= cfg_data_i[0];
        tgr_pkg::REG_CUR_COL:  cur_col_q  <= cfg_data_i[7:0];
        tgr_pkg::REG_CUR_LINE: cur_line_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == tgr_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_font  = in_xfer && (s_axis_tuser_i == tgr_pkg::FUNC_LOAD);
  assign start_text = in_xfer && (s_axis_tuser_i == tgr_pkg::FUNC_RENDER)
                      && (bpp_q == tgr_pkg::BPP_TEXT);
  assign start_pix  = in_xfer && (s_axis_tuser_i == tgr_pkg::FUNC_RENDER)
                      && (bpp_q != tgr_pkg::BPP_TEXT);

  assign load_row    = pend_q && (!out_valid_q || m_axis_tready_i);
  assign render_done = load_row && (out_cnt_q == RowW'(tgr_pkg::GLYPH_ROWS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tgr_pkg::ST_IDLE:   if (start_pix) state_d = tgr_pkg::ST_RENDER;
      tgr_pkg::ST_RENDER: if (render_done) state_d = tgr_pkg::ST_IDLE;
      default:            state_d = tgr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    issue       = 1'b0;
    issue_cnt_d = issue_cnt_q;
    out_cnt_d   = out_cnt_q;
    unique case (state_q)
      tgr_pkg::ST_IDLE: begin
        if (start_pix) begin
          issue_cnt_d = '0;
          out_cnt_d   = '0;
        end
      end
      tgr_pkg::ST_RENDER: begin
        issue = (issue_cnt_q < (RowW+1)'(tgr_pkg::GLYPH_ROWS)) && (!pend_q || load_row);
        if (issue) issue_cnt_d = issue_cnt_q + 1'b1;
        if (load_row) out_cnt_d = out_cnt_q + 1'b1;
      end
      default: ;
    endcase
    pend_d = issue ? 1'b1 : (load_row ? 1'b0 : pend_q);
    out_valid_d = (start_text || load_row) ? 1'b1
                : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgr_pkg::ST_IDLE;
      issue_cnt_q <= '0;
      out_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      out_cnt_q   <= out_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  tgr_ram #(
    .WIDTH (8),
    .DEPTH (tgr_pkg::FONT_DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (load_font),
    .waddr_i ({in_code, in_grow}),
    .wdata_i (in_fbits),
    .re_i    (issue),
    .raddr_i ({code_q, issue_cnt_q[RowW-1:0]}),
    .rdata_o (rdata)
  );

  logic [31:0] text_off, pix_base, col_bytes;
  logic [11:0] ninth_end;
  logic        is32;

  assign is32      = (bpp_q == tgr_pkg::BPP_32);
  assign text_off  = (32'(in_line) * 32'(TEXT_COLUMNS) + 32'(in_col)) << 1;
  assign col_bytes = is32 ? 32'(in_col) * 32'd36 : 32'(in_col) * 32'd27;
  assign pix_base  = 32'(in_line) * 32'(tgr_pkg::GLYPH_ROWS) * 32'(pitch_q) + col_bytes;
  assign ninth_end = (12'(in_col) + 12'd1) * 12'd9;

  logic [8:0] row_fgm, row_wm;
  logic       cursor_row, gfx_bit;

  assign cursor_row = cursor_here_q && (out_cnt_q >= tgr_pkg::CURSOR_ROW_FIRST);
  assign gfx_bit    = ninth_ok_q && line_gfx_q && rdata[0];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      row_fgm[j] = rdata[7-j] || cursor_row;
      row_wm[j]  = row_fgm[j] ? fg_on_q : bg_on_q;
    end
    row_fgm[8] = gfx_bit;
    row_wm[8]  = ninth_ok_q && (gfx_bit ? fg_on_q : bg_on_q);
  end

  always_ff @(posedge clk_i) begin
    if (start_pix) begin
      code_q        <= in_code;
      fgc_q         <= is32 ? in_fg : (in_fg & tgr_pkg::RGB_MASK);
      bgc_q         <= is32 ? in_bg : (in_bg & tgr_pkg::RGB_MASK);
      cursor_here_q <= cur_vis_q && (in_col == cur_col_q) && (in_line == cur_line_q);
      ninth_ok_q    <= 14'(ninth_end) <= width_q;
      line_gfx_q    <= (in_code >= tgr_pkg::LINE_GFX_FIRST)
                       && (in_code <= tgr_pkg::LINE_GFX_LAST);
      fg_on_q       <= (in_fg & tgr_pkg::ALPHA_MASK) != '0;
      bg_on_q       <= (in_bg & tgr_pkg::ALPHA_MASK) != '0;
      row_off_q     <= pix_base;
    end else if (load_row) begin
      row_off_q     <= row_off_q + 32'(pitch_q);
    end

    if (start_text) begin
      out_off_q  <= text_off;
      out_fgm_q  <= '0;
      out_wm_q   <= '0;
      out_fgc_q  <= '0;
      out_bgc_q  <= '0;
      out_ch_q   <= (in_code == tgr_pkg::REPLACE_CODE) ? tgr_pkg::REPLACE_CHAR : in_code;
      out_at_q   <= (in_code == tgr_pkg::REPLACE_CODE) ? tgr_pkg::swap_nibbles(in_attr)
                                                        : in_attr;
      out_last_q <= 1'b1;
    end else if (load_row) begin
      out_off_q  <= row_off_q;
      out_fgm_q  <= row_fgm;
      out_wm_q   <= row_wm;
      out_fgc_q  <= fgc_q;
      out_bgc_q  <= bgc_q;
      out_ch_q   <= '0;
      out_at_q   <= '0;
      out_last_q <= render_done;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {6'd0, out_at_q, out_ch_q, out_bgc_q, out_fgc_q,
                            out_wm_q, out_fgm_q, out_off_q};

  // A fetched row waiting at the memory output is always the next one to deliver.
  a_pend_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (issue_cnt_q == ({1'b0, out_cnt_q} + 1'b1)))
    else $error("fetched glyph row out of step with delivered rows");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgr_pkg::ST_RENDER) |-> !s_axis_tready_o)
    else $error("input accepted during a render");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_row && out_cnt_q == RowW'(tgr_pkg::GLYPH_ROWS - 1)) |=> (state_q == tgr_pkg::ST_IDLE))
    else $error("render did not end after its last row");

  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgr_pkg::ST_IDLE) |-> !pend_q)
    else $error("fetched glyph row left over after a render");

endmodule

FILE: sv/tgr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/tb_text_glyph_row_renderer_top.sv
// Self-checking testbench for the text glyph row renderer: directed and random cells.
`timescale 1ns / 1ps

module tb_text_glyph_row_renderer_top;

  typedef struct packed {
    logic        func;
    logic [7:0]  col;
    logic [7:0]  line;
    logic [7:0]  code;
    logic [3:0]  grow;
    logic [7:0]  font_bits;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [7:0]  attr;
  } cell_item_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [8:0]  fg_mask;
    logic [8:0]  wr_mask;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic [7:0]  chr;
    logic [7:0]  attr;
    logic        last;
  } row_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            src_valid = 1'b0;
  logic [tgr_pkg::IN_DATA_W-1:0]   src_data = '0;
  logic                            src_func = tgr_pkg::FUNC_RENDER;
  logic                            sink_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [tgr_pkg::CFG_IDX_W-1:0]   cfg_index = tgr_pkg::REG_BPP;
  logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  logic                            s_axis_tready_o;
  logic                            m_axis_tvalid_o;
  logic [tgr_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o;
  logic                            m_axis_tlast_o;
  logic                            cfg_ready_o;

  text_glyph_row_renderer_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (src_data),
    .s_axis_tuser_i  (src_func),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (sink_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Register copies as the block should hold them.
  logic [5:0]  cfg_bpp = tgr_pkg::BPP_TEXT;
  logic [15:0] cfg_pitch = '0;
  logic [13:0] cfg_width = tgr_pkg::WIDTH_RESET;
  logic        cfg_cur_vis = 1'b1;
  logic [7:0]  cfg_cur_col = '0;
  logic [7:0]  cfg_cur_line = '0;

  logic [7:0]  glyph_mem [0:tgr_pkg::FONT_DEPTH-1];
  bit          row_written [0:tgr_pkg::FONT_DEPTH-1];
  bit          glyph_ready [0:tgr_pkg::FONT_CHARS-1];
  logic [7:0]  ready_codes [$];

  row_result_t expected_rows [$];

  bit          no_gaps = 1'b0;
  bit          quiet_sink = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned fault_count = 0;
  int unsigned loads_sent = 0;
  int unsigned text_cells = 0;
  int unsigned pixel_cells = 0;
  int unsigned rows_checked = 0;
  int unsigned settings_used = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string row_text(input row_result_t r);
    return $sformatf("off=%h fgm=%h wm=%h fg=%h bg=%h ch=%h at=%h last=%b", r.offset,
                     r.fg_mask, r.wr_mask, r.fg_color, r.bg_color, r.chr, r.attr, r.last);
  endfunction

  task automatic predict_cell(input cell_item_t it);
    row_result_t r;
    int unsigned base;
    int unsigned bytes;
    logic [31:0] cmask;
    logic        cursor_here;
    logic        ninth_ok;
    logic        line_gfx;
    logic        fg_on;
    logic        bg_on;
    logic        is_fg;
    logic [7:0]  glyph;
    bit          complete;
    int          k;
    int          j;
    if (it.func == tgr_pkg::FUNC_LOAD) begin
      glyph_mem[{it.code, it.grow}] = it.font_bits;
      row_written[{it.code, it.grow}] = 1'b1;
      loads_sent++;
      complete = 1'b1;
      for (k = 0; k < tgr_pkg::GLYPH_ROWS; k++) begin
        complete &= row_written[{it.code, 4'(k)}];
      end
      if (complete && !glyph_ready[it.code]) begin
        glyph_ready[it.code] = 1'b1;
        ready_codes.push_back(it.code);
      end
    end else if (cfg_bpp == tgr_pkg::BPP_TEXT) begin
      text_cells++;
      r = '0;
      r.offset = 2 * (32'(it.line) * tgr_pkg::TEXT_COLUMNS_DEF + 32'(it.col));
      r.chr = it.code;
      r.attr = it.attr;
      if (it.code == tgr_pkg::REPLACE_CODE) begin
        r.chr = tgr_pkg::REPLACE_CHAR;
        r.attr = {it.attr[3:0], it.attr[7:4]};
      end
      r.last = 1'b1;
      expected_rows.push_back(r);
    end else begin
      pixel_cells++;
      bytes = (cfg_bpp == tgr_pkg::BPP_32) ? 4 : 3;
      cmask = (cfg_bpp == tgr_pkg::BPP_32) ? 32'hFFFF_FFFF : tgr_pkg::RGB_MASK;
      base = 32'(it.line) * tgr_pkg::GLYPH_ROWS * 32'(cfg_pitch) + 32'(it.col) * 9 * bytes;
      cursor_here = cfg_cur_vis && it.col == cfg_cur_col && it.line == cfg_cur_line;
      ninth_ok = (32'(it.col) + 1) * 9 <= 32'(cfg_width);
      line_gfx = it.code >= tgr_pkg::LINE_GFX_FIRST && it.code <= tgr_pkg::LINE_GFX_LAST;
      fg_on = (it.fg & tgr_pkg::ALPHA_MASK) != 0;
      bg_on = (it.bg & tgr_pkg::ALPHA_MASK) != 0;
      for (k = 0; k < tgr_pkg::GLYPH_ROWS; k++) begin
        glyph = glyph_mem[{it.code, 4'(k)}];
        r = '0;
        for (j = 0; j < 8; j++) begin
          is_fg = glyph[7-j] || (cursor_here && k >= tgr_pkg::CURSOR_ROW_FIRST);
          r.fg_mask[j] = is_fg;
          r.wr_mask[j] = is_fg ? fg_on : bg_on;
        end
        if (ninth_ok) begin
          is_fg = line_gfx && glyph[0];
          r.fg_mask[8] = is_fg;
          r.wr_mask[8] = is_fg ? fg_on : bg_on;
        end
        r.offset = base + 32'(k) * 32'(cfg_pitch);
        r.fg_color = it.fg & cmask;
        r.bg_color = it.bg & cmask;
        r.last = (k == tgr_pkg::GLYPH_ROWS - 1);
        expected_rows.push_back(r);
      end
    end
  endtask

  task automatic check_row(input logic [tgr_pkg::OUT_DATA_W-1:0] d, input logic tl);
    row_result_t got;
    row_result_t want;
    got.offset = d[31:0];
    got.fg_mask = d[40:32];
    got.wr_mask = d[49:41];
    got.fg_color = d[81:50];
    got.bg_color = d[113:82];
    got.chr = d[121:114];
    got.attr = d[129:122];
    got.last = tl;
    rows_checked++;
    if (expected_rows.size() == 0) begin
      fault_count++;
      if (fault_count <= 10) $display("unexpected result: %s", row_text(got));
    end else begin
      want = expected_rows.pop_front();
      if (got.offset !== want.offset || got.fg_mask !== want.fg_mask ||
          got.wr_mask !== want.wr_mask || got.fg_color !== want.fg_color ||
          got.bg_color !== want.bg_color || got.chr !== want.chr ||
          got.attr !== want.attr || got.last !== want.last) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("mismatch at %0t: expected %s", $realtime, row_text(want));
          $display("                actual   %s", row_text(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && sink_ready) begin
        check_row(m_axis_tdata_o, m_axis_tlast_o);
        sink_hold = quiet_sink ? 0 : $urandom_range(0, 15);
      end
      if (sink_hold != 0) begin
        sink_ready <= 1'b0;
        sink_hold--;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input cell_item_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_func <= it.func;
    src_data <= {4'b0, it.attr, it.bg, it.fg, it.font_bits, it.grow, it.code, it.line, it.col};
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    predict_cell(it);
  endtask

  task automatic wait_until_idle();
    src_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tgr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tgr_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      tgr_pkg::REG_BPP:      cfg_bpp = val[5:0];
      tgr_pkg::REG_PITCH:    cfg_pitch = val;
      tgr_pkg::REG_WIDTH:    cfg_width = val[13:0];
      tgr_pkg::REG_CUR_VIS:  cfg_cur_vis = val[0];
      tgr_pkg::REG_CUR_COL:  cfg_cur_col = val[7:0];
      tgr_pkg::REG_CUR_LINE: cfg_cur_line = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [5:0] bpp, input logic [15:0] pitch,
                           input logic [13:0] width, input logic vis,
                           input logic [7:0] ccol, input logic [7:0] cline);
    write_reg(tgr_pkg::REG_BPP, {10'd0, bpp});
    write_reg(tgr_pkg::REG_PITCH, pitch);
    write_reg(tgr_pkg::REG_WIDTH, {2'd0, width});
    write_reg(tgr_pkg::REG_CUR_VIS, {15'd0, vis});
    write_reg(tgr_pkg::REG_CUR_COL, {8'd0, ccol});
    write_reg(tgr_pkg::REG_CUR_LINE, {8'd0, cline});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic cell_item_t random_fields();
    cell_item_t it;
    it.func = tgr_pkg::FUNC_RENDER;
    it.col = 8'($urandom);
    it.line = 8'($urandom);
    it.code = 8'($urandom);
    it.grow = 4'($urandom);
    it.font_bits = 8'($urandom);
    it.fg = $urandom;
    it.bg = $urandom;
    it.attr = 8'($urandom);
    return it;
  endfunction

  function automatic cell_item_t make_render(input logic [7:0] col, input logic [7:0] line,
                                             input logic [7:0] code, input logic [31:0] fg,
                                             input logic [31:0] bg, input logic [7:0] attr);
    cell_item_t it;
    it = random_fields();
    it.col = col;
    it.line = line;
    it.code = code;
    it.fg = fg;
    it.bg = bg;
    it.attr = attr;
    return it;
  endfunction

  function automatic cell_item_t make_load(input logic [7:0] code, input logic [3:0] grow,
                                           input logic [7:0] font_bits);
    cell_item_t it;
    it = random_fields();
    it.func = tgr_pkg::FUNC_LOAD;
    it.code = code;
    it.grow = grow;
    it.font_bits = font_bits;
    return it;
  endfunction

  function automatic cell_item_t random_cell();
    cell_item_t it;
    int unsigned edge_col;
    it = random_fields();
    edge_col = 32'(cfg_width) / 9;
    if ($urandom_range(0, 3) == 0) begin
      it.col = cfg_cur_col;
      it.line = cfg_cur_line;
    end else if ($urandom_range(0, 4) == 0 && edge_col >= 1 && edge_col <= 256) begin
      it.col = 8'(edge_col - $urandom_range(0, 1));
    end
    if (cfg_bpp == tgr_pkg::BPP_TEXT) begin
      if ($urandom_range(0, 5) == 0) it.code = tgr_pkg::REPLACE_CODE;
    end else begin
      it.code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    end
    if ($urandom_range(0, 4) == 0) it.fg[31:24] = 8'h00;
    if ($urandom_range(0, 4) == 0) it.bg[31:24] = 8'h00;
    return it;
  endfunction

  task automatic load_glyph(input logic [7:0] code);
    logic [7:0] pattern;
    int r;
    for (r = 0; r < tgr_pkg::GLYPH_ROWS; r++) begin
      case (r)
        0:       pattern = 8'hFF;
        1:       pattern = 8'h00;
        2:       pattern = 8'h01;
        3:       pattern = 8'h80;
        default: pattern = 8'($urandom);
      endcase
      send_item(make_load(code, 4'(r), pattern));
    end
  endtask

  task automatic test_font_load();
    load_glyph(8'h00);
    load_glyph(8'hAF);
    load_glyph(tgr_pkg::LINE_GFX_FIRST);
    load_glyph(tgr_pkg::LINE_GFX_LAST);
    load_glyph(8'hE0);
    wait_until_idle();
  endtask

  task automatic test_text_mode();
    configure(tgr_pkg::BPP_TEXT, 16'hFFFF, 14'h3FFF, 1'b1, 8'd0, 8'd0);
    send_item(make_render(8'd0, 8'd0, 8'h41, $urandom, $urandom, 8'h1F));
    send_item(make_render(8'd255, 8'd255, tgr_pkg::REPLACE_CODE, $urandom, $urandom, 8'h5A));
    send_item(make_render(8'd79, 8'd24, 8'hFE, $urandom, $urandom, 8'hFF));
    send_item(make_render(8'd0, 8'd255, 8'h00, $urandom, $urandom, 8'h00));
    send_item(make_render(8'd255, 8'd0, tgr_pkg::REPLACE_CHAR, $urandom, $urandom, 8'hF0));
    send_item(make_render(8'd128, 8'd127, tgr_pkg::REPLACE_CODE, $urandom, $urandom, 8'h0F));
    wait_until_idle();
  endtask

  task automatic test_cursor_and_line_gfx();
    configure(tgr_pkg::BPP_32, 16'hFFFF, 14'h3FFF, 1'b1, 8'd255, 8'd255);
    send_item(make_render(8'd255, 8'd255, tgr_pkg::LINE_GFX_FIRST, 32'hFF11_2233,
                          32'h8044_5566, 8'h00));
    send_item(make_render(8'd255, 8'd255, tgr_pkg::LINE_GFX_LAST, 32'h00AB_CDEF,
                          32'hFF00_0001, 8'h00));
    send_item(make_render(8'd0, 8'd0, 8'hE0, 32'hFFFF_FFFF, 32'h00FF_FFFF, 8'h00));
    send_item(make_render(8'd254, 8'd255, 8'hAF, 32'h0012_3456, 32'h0065_4321, 8'h00));
    send_item(make_render(8'd0, 8'd0, 8'h00, 32'h1234_5678, 32'h8765_4321, 8'h00));
    send_item(make_render(8'd255, 8'd254, tgr_pkg::LINE_GFX_LAST, 32'h0100_0000,
                          32'h0000_0000, 8'h00));
    wait_until_idle();
  endtask

  task automatic test_edge_clip();
    configure(6'd24, 16'h0000, tgr_pkg::WIDTH_RESET, 1'b0, 8'd71, 8'd0);
    send_item(make_render(8'd70, 8'd0, tgr_pkg::LINE_GFX_FIRST, 32'hFFAA_BBCC,
                          32'hFF00_1122, 8'h00));
    send_item(make_render(8'd71, 8'd0, tgr_pkg::LINE_GFX_FIRST, 32'hFFAA_BBCC,
                          32'hFF00_1122, 8'h00));
    send_item(make_render(8'd72, 8'd3, tgr_pkg::LINE_GFX_LAST, 32'h7F00_0000,
                          32'h00FF_FFFF, 8'h00));
    wait_until_idle();
    configure(6'd17, 16'd1234, 14'd0, 1'b1, 8'd0, 8'd0);
    send_item(make_render(8'd0, 8'd0, tgr_pkg::LINE_GFX_FIRST, 32'hFF12_3456,
                          32'hFF65_4321, 8'h00));
    send_item(make_render(8'd9, 8'd200, 8'h00, 32'hFF12_3456, 32'hFF65_4321, 8'h00));
    wait_until_idle();
  endtask

  task automatic test_random_cells();
    logic [5:0]  bpp;
    logic [15:0] pitch;
    logic [13:0] width;
    int          phase;
    int unsigned sent;
    int unsigned pick;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       bpp = 6'd24;
        1:       bpp = tgr_pkg::BPP_32;
        2:       bpp = tgr_pkg::BPP_TEXT;
        default: bpp = 6'($urandom_range(1, 32));
      endcase
      case ($urandom_range(0, 3))
        0:       pitch = 16'h0000;
        1:       pitch = 16'hFFFF;
        default: pitch = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       width = 14'd0;
        1:       width = 14'h3FFF;
        2:       width = tgr_pkg::WIDTH_RESET;
        default: width = 14'($urandom);
      endcase
      no_gaps = (phase == 1);
      quiet_sink = (phase == 3);
      configure(bpp, pitch, width, 1'($urandom), 8'($urandom), 8'($urandom));
      sent = 0;
      while (sent < 15) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          load_glyph(8'($urandom));
          sent += tgr_pkg::GLYPH_ROWS;
        end else if (pick == 1) begin
          send_item(make_load(8'($urandom), 4'($urandom), 8'($urandom)));
          sent++;
        end else begin
          send_item(random_cell());
          sent++;
        end
      end
      wait_until_idle();
      no_gaps = 1'b0;
      quiet_sink = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_font_load();
    test_text_mode();
    test_cursor_and_line_gfx();
    test_edge_clip();
    test_random_cells();
    wait_until_idle();
    fault_count += expected_rows.size();
    $display("Covered %0d font row loads, %0d text cells and %0d pixel cells over %0d settings.",
             loads_sent, text_cells, pixel_cells, settings_used);
    $display("Checked %0d results; %0d failures.", rows_checked, fault_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Run timed out with %0d results outstanding.", expected_rows.size());
    $display("status: fail");
    $finish;
  end

endmodule
